// ===== src/assert_macros.svh =====
// ------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesizing
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold on every clock outside reset
`define SCLIP_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define SCLIP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define SCLIP_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define SCLIP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/sclip_pkg.sv =====
// ------------------------------------------------------------------------
// sclip_pkg
// shared types, constants and plane table of the segment clipper
// ------------------------------------------------------------------------
package sclip_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_W          = 288;
  localparam int OUT_W         = 88;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 12;
  localparam int NPLANES       = 6;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_EN  = 2'd0,
    REG_VP_WIDTH  = 2'd1,
    REG_VP_HEIGHT = 2'd2,
    REG_BORDER    = 2'd3
  } cfg_reg_t;

  typedef enum int {AXIS_X = 0, AXIS_Y = 1, AXIS_Z = 2} axis_t;

  typedef logic [2:0][31:0] vec3_t;
  typedef vec3_t [1:0]      seg_t;

  // per item data that rides along the pipeline
  typedef struct packed {
    logic        alive;
    logic [23:0] color;
    logic [7:0]  width;
  } side_t;

  // tag carried through the w divider
  typedef struct packed {
    side_t      side;
    logic [5:0] neg;
    logic [5:0] azero;
  } wtag_t;

  // tag carried through one clip plane
  typedef struct packed {
    side_t      side;
    logic       strad;
    logic       isel;
    logic [2:0] dneg;
    vec3_t      icrd;
    seg_t       pts;
  } ptag_t;

  // plane order: x low, x high, y low, y high, z low, z high
  function automatic int plane_axis(input int pl);
    case (pl)
      0, 1:    return AXIS_X;
      2, 3:    return AXIS_Y;
      default: return AXIS_Z;
    endcase
  endfunction

  function automatic logic plane_upper(input int pl);
    case (pl)
      1, 3, 5: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic signed [32:0] plane_k(input int pl, input int frac);
    case (pl)
      0, 2:    return -(33'sd1 <<< frac);
      4:       return 33'sd0;
      default: return 33'sd1 <<< frac;
    endcase
  endfunction

  function automatic logic [32:0] abs33(input logic [32:0] v);
    return v[32] ? (~v + 33'd1) : v;
  endfunction

endpackage

// ===== src/segment_clip_and_viewport_map.sv =====
// ------------------------------------------------------------------------
// segment_clip_and_viewport_map
// homogeneous 3d segment clipper with viewport mapping and depth color
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+--------------------------------
//   s_      | in  | s_tvalid / s_tready | one segment request
//   m_      | out | m_tvalid / m_tready | one result per segment
//   cfg_    | in  | cfg_we              | register index and data
//
// one segment enters per cycle while m_tready does not stall the output: 1 input stage,
// 33 stages of the w divider, 1 saturation stage, 39 per clip plane
// (4 setup, 34 interpolation divider, 1 update) and 3 mapping stages.
// rst is synchronous, clears the valid bits and resets the configuration registers (border to 10).
// a stall on m_tready freezes the whole pipeline; s_tready drops with it.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_clip_and_viewport_map #(
  parameter int FRAC_BITS = sclip_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // start x,y,z,w, end x,y,z,w (32 each), line_color (24), line_width (8)
  input  logic [sclip_pkg::IN_W-1:0]       s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // visible (1), out_start_x, out_start_y, out_end_x, out_end_y (13 each),
  // pen_color (24), pen_width (8), zero fill (3)
  output logic [sclip_pkg::OUT_W-1:0]      m_tdata,
  input  logic                             cfg_we,
  input  logic [sclip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sclip_pkg::CFG_DATA_W-1:0] cfg_data
);

  import sclip_pkg::*;

  localparam int NWW   = 32 + FRAC_BITS;
  localparam int XW    = FRAC_BITS + 2;
  localparam int PW    = FRAC_BITS + 14;
  localparam int SW    = FRAC_BITS + 15;
  localparam int TDW   = FRAC_BITS + 11;
  localparam logic signed [32:0] ONE_S = 33'sd1 <<< FRAC_BITS;

  // configuration registers
  logic        depth_en;
  logic [11:0] vp_width;
  logic [11:0] vp_height;
  logic [7:0]  border;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_en  <= 1'b0;
      vp_width  <= 12'd0;
      vp_height <= 12'd0;
      border    <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEPTH_EN:  depth_en  <= cfg_data[0];
        REG_VP_WIDTH:  vp_width  <= cfg_data[11:0];
        REG_VP_HEIGHT: vp_height <= cfg_data[11:0];
        REG_BORDER:    border    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // global advance
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // input stage: magnitudes and signs
  logic              s2_vld;
  logic [5:0][31:0]  s2_amag;
  logic [1:0][31:0]  s2_wmag;
  wtag_t             s2_tag;
  logic [5:0][31:0]  in_crd;
  logic [1:0][31:0]  in_w;

  for (genvar l = 0; l < 6; l++) begin : g_in
    assign in_crd[l] = s_tdata[32*(l + l/3) +: 32];
  end
  assign in_w[0] = s_tdata[127:96];
  assign in_w[1] = s_tdata[255:224];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 6; l++) begin
        s2_amag[l]      <= in_crd[l][31] ? (~in_crd[l] + 32'd1) : in_crd[l];
        s2_tag.neg[l]   <= in_crd[l][31] ^ in_w[l/3][31];
        s2_tag.azero[l] <= in_crd[l] == 32'd0;
      end
      for (int e = 0; e < 2; e++) begin
        s2_wmag[e] <= in_w[e][31] ? (~in_w[e] + 32'd1) : in_w[e];
      end
      s2_tag.side.alive <= !(in_w[0][31] && in_w[1][31]);
      s2_tag.side.color <= s_tdata[279:256];
      s2_tag.side.width <= s_tdata[287:280];
    end
  end

  // perspective divide
  logic [5:0][NWW-1:0] w_num;
  logic [5:0][31:0]    w_den;
  logic                w_vld;
  logic [5:0][31:0]    w_q;
  logic [5:0]          w_ov;
  wtag_t               w_tag;

  for (genvar l = 0; l < 6; l++) begin : g_wnum
    assign w_num[l] = {s2_amag[l], {FRAC_BITS{1'b0}}};
    assign w_den[l] = s2_wmag[l/3];
  end

  sclip_div #(
    .LANES (6),
    .NW    (NWW),
    .DW    (32),
    .QW    (32),
    .TW    ($bits(wtag_t))
  ) u_wdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s2_vld),
    .num       (w_num),
    .den       (w_den),
    .tag_in    (s2_tag),
    .out_valid (w_vld),
    .q         (w_q),
    .ovf       (w_ov),
    .tag_out   (w_tag)
  );

  // plane chain links
  seg_t  pl_pts  [NPLANES+1];
  side_t pl_side [NPLANES+1];
  logic  pl_vld  [NPLANES+1];

  // saturate and sign the quotients
  seg_t pts0_next;

  always_comb begin
    logic [32:0] lim;
    logic [32:0] m;
    for (int l = 0; l < 6; l++) begin
      lim = w_tag.neg[l] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      m   = (w_ov[l] || ({1'b0, w_q[l]} > lim)) ? lim : {1'b0, w_q[l]};
      if (w_tag.azero[l]) begin
        pts0_next[l/3][l%3] = 32'd0;
      end else if (w_tag.neg[l]) begin
        pts0_next[l/3][l%3] = 32'(~m + 33'd1);
      end else begin
        pts0_next[l/3][l%3] = m[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pl_vld[0] <= 1'b0;
    end else if (adv) begin
      pl_vld[0] <= w_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_pts[0]  <= pts0_next;
      pl_side[0] <= w_tag.side;
    end
  end

  // clip planes
  for (genvar pl = 0; pl < NPLANES; pl++) begin : g_plane
    localparam int AX = plane_axis(pl);
    localparam logic UP = plane_upper(pl);
    localparam logic signed [32:0] KV = plane_k(pl, FRAC_BITS);

    logic signed [32:0] pa, pb;
    logic               out0, out1, strad;

    // classify the two ends
    assign pa    = {pl_pts[pl][0][AX][31], pl_pts[pl][0][AX]};
    assign pb    = {pl_pts[pl][1][AX][31], pl_pts[pl][1][AX]};
    assign out0  = UP ? (pa > KV) : (pa < KV);
    assign out1  = UP ? (pb > KV) : (pb < KV);
    assign strad = ((pa < KV) && (pb > KV)) || ((pa > KV) && (pb < KV));

    logic  a_vld, a_strad, a_isel;
    seg_t  a_pts;
    side_t a_side;
    vec3_t a_i, a_o;

    always_ff @(posedge clk) begin
      if (rst) begin
        a_vld <= 1'b0;
      end else if (adv) begin
        a_vld <= pl_vld[pl];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_pts   <= pl_pts[pl];
        a_side  <= {pl_side[pl].alive && !(out0 && out1), pl_side[pl].color,
                    pl_side[pl].width};
        a_strad <= strad;
        a_isel  <= out0;
        a_i     <= out0 ? pl_pts[pl][1] : pl_pts[pl][0];
        a_o     <= out0 ? pl_pts[pl][0] : pl_pts[pl][1];
      end
    end

    // differences from the inside end
    logic [2:0][32:0] dd;
    logic [32:0]      kd;

    for (genvar c = 0; c < 3; c++) begin : g_diff
      assign dd[c] = {a_o[c][31], a_o[c]} - {a_i[c][31], a_i[c]};
    end
    assign kd = KV - {a_i[AX][31], a_i[AX]};

    logic             b_vld;
    ptag_t            b_tag;
    logic [2:0][32:0] b_dm;
    logic [32:0]      b_num, b_den;

    always_ff @(posedge clk) begin
      if (rst) begin
        b_vld <= 1'b0;
      end else if (adv) begin
        b_vld <= a_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        b_tag.side  <= a_side;
        b_tag.strad <= a_strad;
        b_tag.isel  <= a_isel;
        b_tag.icrd  <= a_i;
        b_tag.pts   <= a_pts;
        for (int c = 0; c < 3; c++) begin
          b_tag.dneg[c] <= dd[c][32];
          b_dm[c]       <= abs33(dd[c]);
        end
        b_num <= abs33(kd);
        b_den <= abs33(dd[AX]);
      end
    end

    // partial products of |d| * num
    logic             c_vld;
    ptag_t            c_tag;
    logic [32:0]      c_den;
    logic [2:0][33:0] c_ll;
    logic [2:0][32:0] c_lh, c_hl;
    logic [2:0][31:0] c_hh;

    always_ff @(posedge clk) begin
      if (rst) begin
        c_vld <= 1'b0;
      end else if (adv) begin
        c_vld <= b_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        c_tag <= b_tag;
        c_den <= b_den;
        for (int c = 0; c < 3; c++) begin
          c_ll[c] <= 34'(b_dm[c][16:0]) * 34'(b_num[16:0]);
          c_lh[c] <= 33'(b_dm[c][16:0]) * 33'(b_num[32:17]);
          c_hl[c] <= 33'(b_dm[c][32:17]) * 33'(b_num[16:0]);
          c_hh[c] <= 32'(b_dm[c][32:17]) * 32'(b_num[32:17]);
        end
      end
    end

    // sum the partial products
    logic             d_vld;
    ptag_t            d_tag;
    logic [2:0][32:0] d_den;
    logic [2:0][65:0] d_prod;

    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld <= 1'b0;
      end else if (adv) begin
        d_vld <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_tag <= c_tag;
        for (int c = 0; c < 3; c++) begin
          d_den[c]  <= c_den;
          d_prod[c] <= 66'(c_ll[c]) + ((66'(c_lh[c]) + 66'(c_hl[c])) << 17)
                     + (66'(c_hh[c]) << 34);
        end
      end
    end

    // interpolation divide
    logic             v_vld;
    logic [2:0][32:0] v_q;
    logic [2:0]       v_ov;
    ptag_t            v_tag;

    sclip_div #(
      .LANES (3),
      .NW    (66),
      .DW    (33),
      .QW    (33),
      .TW    ($bits(ptag_t))
    ) u_idiv (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (d_vld),
      .num       (d_prod),
      .den       (d_den),
      .tag_in    (d_tag),
      .out_valid (v_vld),
      .q         (v_q),
      .ovf       (v_ov),
      .tag_out   (v_tag)
    );

    // move the outside end onto the plane
    vec3_t nv;
    seg_t  pts_next;

    always_comb begin
      logic [32:0] m;
      for (int c = 0; c < 3; c++) begin
        m     = v_ov[c] ? '1 : v_q[c];
        nv[c] = 32'({v_tag.icrd[c][31], v_tag.icrd[c]}
                    + (v_tag.dneg[c] ? (~m + 33'd1) : m));
      end
      pts_next = v_tag.pts;
      if (v_tag.strad) begin
        if (v_tag.isel) begin
          pts_next[0] = nv;
        end else begin
          pts_next[1] = nv;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pl_vld[pl+1] <= 1'b0;
      end else if (adv) begin
        pl_vld[pl+1] <= v_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pl_pts[pl+1]  <= pts_next;
        pl_side[pl+1] <= v_tag.side;
      end
    end
  end

  // mapping stage 1: offsets and depth difference
  logic             m1_vld, m1_dpos, m1_dnpos;
  side_t            m1_side;
  logic [1:0][XW-1:0] m1_xs, m1_ys;
  logic [FRAC_BITS:0] m1_dmag;
  logic [32:0]      zsum;
  logic [32:0]      zdv;

  assign zsum = {pl_pts[NPLANES][0][2][31], pl_pts[NPLANES][0][2]}
              + {pl_pts[NPLANES][1][2][31], pl_pts[NPLANES][1][2]};
  assign zdv  = zsum - ONE_S;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else if (adv) begin
      m1_vld <= pl_vld[NPLANES];
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] xo, yo;
    logic [32:0] za;
    if (adv) begin
      for (int e = 0; e < 2; e++) begin
        xo = pl_pts[NPLANES][e][0] + ONE_S[31:0];
        yo = pl_pts[NPLANES][e][1] + ONE_S[31:0];
        m1_xs[e] <= xo[XW-1:0];
        m1_ys[e] <= yo[XW-1:0];
      end
      za = abs33(zdv);
      m1_dmag  <= za[FRAC_BITS:0];
      m1_dpos  <= !zdv[32];
      m1_dnpos <= zdv[32] || (zdv == 33'd0);
      m1_side  <= pl_side[NPLANES];
    end
  end

  // mapping stage 2: viewport scaling and depth product
  logic               m2_vld, m2_dpos, m2_dnpos;
  side_t              m2_side;
  logic [1:0][PW-1:0] m2_px, m2_py;
  logic [TDW-1:0]     m2_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else if (adv) begin
      m2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < 2; e++) begin
        m2_px[e] <= PW'(m1_xs[e]) * PW'(vp_width);
        m2_py[e] <= PW'(m1_ys[e]) * PW'(vp_height);
      end
      m2_t     <= TDW'(m1_dmag) * TDW'(510) + (TDW'(1) << FRAC_BITS);
      m2_dpos  <= m1_dpos;
      m2_dnpos <= m1_dnpos;
      m2_side  <= m1_side;
    end
  end

  // mapping stage 3: pixel offsets, color select, output register
  logic [SW-1:0]       xoff, ycon;
  logic [1:0][SW-1:0]  nx, ny;
  logic [7:0]          dval, dr, dg, db;
  logic [23:0]         pen;

  assign xoff = SW'({border, 1'b0} + 10'd3) << FRAC_BITS;
  assign ycon = SW'({1'b0, vp_height, 1'b0} + {5'd0, border, 1'b0} + 14'd3) << FRAC_BITS;

  for (genvar e = 0; e < 2; e++) begin : g_map
    assign nx[e] = SW'(m2_px[e]) + xoff;
    assign ny[e] = ycon - SW'(m2_py[e]);
  end

  assign dval = m2_t[FRAC_BITS+1 +: 8];
  assign dr   = m2_dpos ? dval : 8'd0;
  assign dg   = m2_dnpos ? dval : 8'd0;
  assign db   = 8'd255 - dval;
  assign pen  = (m2_side.color == 24'd0 && depth_en) ? {dr, dg, db} : m2_side.color;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (m2_side.alive) begin
        m_tdata <= {3'b000, m2_side.width, pen,
                    ny[1][FRAC_BITS+1 +: 13], nx[1][FRAC_BITS+1 +: 13],
                    ny[0][FRAC_BITS+1 +: 13], nx[0][FRAC_BITS+1 +: 13], 1'b1};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  // checks
  logic [13:0] px_max;
  logic        px_ok;

  assign px_max = {2'b00, vp_width} + {6'd0, border} + 14'd1;
  assign px_ok  = ({1'b0, m_tdata[13:1]} <= px_max) && ({1'b0, m_tdata[39:27]} <= px_max);

  `SCLIP_ASSERT_IMPL(a_reject_zero, clk, rst, m_tvalid && !m_tdata[0], m_tdata == '0, "rejected payload")
  `SCLIP_ASSERT_IMPL(a_stall_hold, clk, rst, m_tvalid && !m_tready, !s_tready, "input open in stall")
  `SCLIP_ASSERT_IMPL(a_px_range, clk, rst, m_tvalid && m_tdata[0], px_ok, "column outside viewport")

endmodule

// ===== src/sclip_div.sv =====
// ------------------------------------------------------------------------
// sclip_div
// pipelined restoring divider, one quotient bit per stage, several lanes
// ------------------------------------------------------------------------
module sclip_div #(
  parameter int LANES = 1,
  parameter int NW    = 64,
  parameter int DW    = 32,
  parameter int QW    = 32,
  parameter int TW    = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   num,
  input  logic [LANES-1:0][DW-1:0]   den,
  input  logic [TW-1:0]              tag_in,
  output logic                       out_valid,
  output logic [LANES-1:0][QW-1:0]   q,
  output logic [LANES-1:0]           ovf,
  output logic [TW-1:0]              tag_out
);

  localparam int HW = NW - QW;

  logic                     vld [QW+1];
  logic [TW-1:0]            tg  [QW+1];
  logic [LANES-1:0][DW-1:0] rem [QW+1];
  logic [LANES-1:0][DW-1:0] dn  [QW+1];
  logic [LANES-1:0][QW-1:0] lq  [QW+1];
  logic [LANES-1:0]         ov  [QW+1];

  // entry stage: overflow check on the high part
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tg[0] <= tag_in;
      for (int l = 0; l < LANES; l++) begin
        ov[0][l]  <= {{DW{1'b0}}, num[l][NW-1:QW]} >= {{HW{1'b0}}, den[l]};
        rem[0][l] <= DW'(num[l][NW-1:QW]);
        lq[0][l]  <= num[l][QW-1:0];
        dn[0][l]  <= den[l];
      end
    end
  end

  // one quotient bit per stage
  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic [LANES-1:0][DW:0]   t;
    logic [LANES-1:0]         ge;
    logic [LANES-1:0][DW-1:0] rem_next;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t[l]        = {rem[s-1][l], lq[s-1][l][QW-1]};
        ge[l]       = t[l] >= {1'b0, dn[s-1][l]};
        rem_next[l] = ge[l] ? DW'(t[l] - {1'b0, dn[s-1][l]}) : t[l][DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tg[s]  <= tg[s-1];
        ov[s]  <= ov[s-1];
        dn[s]  <= dn[s-1];
        rem[s] <= rem_next;
        for (int l = 0; l < LANES; l++) begin
          lq[s][l] <= {lq[s-1][l][QW-2:0], ge[l]};
        end
      end
    end
  end

  assign out_valid = vld[QW];
  assign q         = lq[QW];
  assign ovf       = ov[QW];
  assign tag_out   = tg[QW];

endmodule

// ===== tb/testbench.sv =====
// ------------------------------------------------------------------------
// testbench
// self-checking bench for the segment clipper: a scoreboard predicts each
// segment result from the accepted request and the register settings,
// and compares it field by field with every result the block returns
// ------------------------------------------------------------------------

// one segment request as seen on s_tdata
typedef struct packed {
  logic [7:0]         width;
  logic [23:0]        color;
  logic signed [31:0] ew, ez, ey, ex;
  logic signed [31:0] sw, sz, sy, sx;
} seg_req_t;

// one result as seen on m_tdata
typedef struct packed {
  logic [2:0]  fill;
  logic [7:0]  pen_width;
  logic [23:0] pen_color;
  logic [12:0] ey, ex, sy, sx;
  logic        visible;
} seg_res_t;

class clip_scoreboard;
  localparam longint ONE = 64'sd1 <<< 16;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;

  bit          depth_en;
  longint      vp_w, vp_h, border;
  seg_res_t    pending[$];
  longint      pt[2][3];
  int          mismatches;
  int          checked;
  int          shown_vis;

  function new();
    depth_en = 0;
    vp_w = 0;
    vp_h = 0;
    border = 10;
    mismatches = 0;
    checked = 0;
    shown_vis = 0;
  endfunction

  function longint unsigned mag(longint v);
    longint unsigned r;
    r = v;
    if (v < 0) r = -v;
    return r;
  endfunction

  // w division with saturation, zero w saturates by numerator sign
  function longint wdiv(longint a, longint w);
    longint unsigned q;
    if (w == 0) return (a > 0) ? CMAX : ((a < 0) ? CMIN : 0);
    q = (mag(a) << 16) / mag(w);
    if ((a < 0) != (w < 0)) begin
      if (q > 64'd2147483648) q = 64'd2147483648;
      return -longint'(q);
    end
    if (q > 64'd2147483647) q = 64'd2147483647;
    return longint'(q);
  endfunction

  // one clip plane on pt, returns 0 on rejection
  function bit clip_plane(int axis, longint k, bit upper);
    longint a, b, d;
    bit out0, out1;
    int i, o;
    longint unsigned num, den, m;
    a = pt[0][axis];
    b = pt[1][axis];
    out0 = upper ? (a > k) : (a < k);
    out1 = upper ? (b > k) : (b < k);
    if (out0 && out1) return 0;
    if ((a < k && b > k) || (a > k && b < k)) begin
      i = out0 ? 1 : 0;
      o = 1 - i;
      num = mag(k - pt[i][axis]);
      den = mag(pt[o][axis] - pt[i][axis]);
      for (int c = 0; c < 3; c++) begin
        d = pt[o][c] - pt[i][c];
        m = mag(d) * num / den;
        pt[o][c] = pt[i][c] + ((d < 0) ? -longint'(m) : longint'(m));
      end
    end
    return 1;
  endfunction

  function longint chan(longint v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  function seg_res_t clip_and_map(seg_req_t q);
    seg_res_t r;
    bit ok;
    longint nx, ny, s, dv, rd, gr, bl;
    r = '0;
    if (q.sw < 0 && q.ew < 0) return r;
    pt[0][0] = wdiv(q.sx, q.sw);
    pt[0][1] = wdiv(q.sy, q.sw);
    pt[0][2] = wdiv(q.sz, q.sw);
    pt[1][0] = wdiv(q.ex, q.ew);
    pt[1][1] = wdiv(q.ey, q.ew);
    pt[1][2] = wdiv(q.ez, q.ew);
    ok = clip_plane(0, -ONE, 0);
    ok = ok && clip_plane(0, ONE, 1);
    ok = ok && clip_plane(1, -ONE, 0);
    ok = ok && clip_plane(1, ONE, 1);
    ok = ok && clip_plane(2, 0, 0);
    ok = ok && clip_plane(2, ONE, 1);
    if (!ok) return r;
    r.visible = 1;
    nx = (pt[0][0] + ONE) * vp_w + (2 * border + 3) * ONE;
    ny = (2 * vp_h + 2 * border + 3) * ONE - (pt[0][1] + ONE) * vp_h;
    r.sx = 13'(nx / (2 * ONE));
    r.sy = 13'(ny / (2 * ONE));
    nx = (pt[1][0] + ONE) * vp_w + (2 * border + 3) * ONE;
    ny = (2 * vp_h + 2 * border + 3) * ONE - (pt[1][1] + ONE) * vp_h;
    r.ex = 13'(nx / (2 * ONE));
    r.ey = 13'(ny / (2 * ONE));
    r.pen_color = q.color;
    // depth color from mean z for black segments
    if (q.color == 0 && depth_en) begin
      s = pt[0][2] + pt[1][2];
      dv = s - ONE;
      rd = 0;
      gr = 0;
      if (dv >= 0) rd = (510 * dv + ONE) / (2 * ONE);
      if (dv <= 0) gr = (510 * (-dv) + ONE) / (2 * ONE);
      bl = 255 - longint'((64'd510 * mag(dv) + 64'd65536) / 64'd131072);
      r.pen_color = {8'(chan(rd)), 8'(chan(gr)), 8'(chan(bl))};
    end
    r.pen_width = q.width;
    return r;
  endfunction

  function void note_request(seg_req_t q);
    pending.push_back(clip_and_map(q));
  endfunction

  function void check_result(seg_res_t got);
    seg_res_t exp_r;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_r = pending.pop_front();
    checked++;
    if (exp_r.visible) shown_vis++;
    if (got.visible !== exp_r.visible || got.sx !== exp_r.sx || got.sy !== exp_r.sy ||
        got.ex !== exp_r.ex || got.ey !== exp_r.ey || got.pen_color !== exp_r.pen_color ||
        got.pen_width !== exp_r.pen_width || got.fill !== exp_r.fill) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: exp vis=%0d s=(%0d,%0d) e=(%0d,%0d) col=%h w=%0d",
                 exp_r.visible, exp_r.sx, exp_r.sy, exp_r.ex, exp_r.ey, exp_r.pen_color,
                 exp_r.pen_width);
        $display("          got vis=%0d s=(%0d,%0d) e=(%0d,%0d) col=%h w=%0d",
                 got.visible, got.sx, got.sy, got.ex, got.ey, got.pen_color,
                 got.pen_width);
      end
    end
  endfunction
endclass

module testbench;
  import sclip_pkg::*;

  localparam int ONE_I = 1 << 16;
  localparam int DRAIN = 300;
  localparam int WATCH_LIMIT = 40000;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [IN_W-1:0] s_tdata;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int send_idle, recv_idle;
  int idle_cycles;
  int sent;
  clip_scoreboard sb;

  segment_clip_and_viewport_map dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // result check, sampled away from the active edge
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(seg_res_t'(m_tdata));
  end

  // watchdog on cycles with no handshake
  always @(negedge clk) begin
    if (rst || (m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCH_LIMIT);
      $display("** segment_clip_and_viewport_map: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, int val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    case (idx)
      REG_DEPTH_EN:  sb.depth_en = val[0];
      REG_VP_WIDTH:  sb.vp_w = val[11:0];
      REG_VP_HEIGHT: sb.vp_h = val[11:0];
      default:       sb.border = val[7:0];
    endcase
  endtask

  task automatic wait_drained();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_viewport(int en, int w, int h, int b);
    wait_drained();
    write_reg(REG_DEPTH_EN, en);
    write_reg(REG_VP_WIDTH, w);
    write_reg(REG_VP_HEIGHT, h);
    write_reg(REG_BORDER, b);
    cfg_we <= 0;
  endtask

  // drive one request, with a random gap before it
  task automatic send_seg(seg_req_t q);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= q;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    sb.note_request(q);
    sent++;
    @(posedge clk);
  endtask

  task automatic send_pts(int sx, int sy, int sz, int sw, int ex, int ey, int ez, int ew,
                          int color, int width);
    seg_req_t q;
    q.sx = sx; q.sy = sy; q.sz = sz; q.sw = sw;
    q.ex = ex; q.ey = ey; q.ez = ez; q.ew = ew;
    q.color = 24'(color);
    q.width = 8'(width);
    send_seg(q);
  endtask

  function automatic int near_coord();
    return $urandom_range(4 * ONE_I) - 2 * ONE_I;
  endfunction

  // mostly in-range segments with random content, plus raw noise
  task automatic send_random(int n);
    seg_req_t q;
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        q = seg_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom});
      end else begin
        q.sx = near_coord(); q.sy = near_coord(); q.sz = near_coord() / 2 + ONE_I / 2;
        q.ex = near_coord(); q.ey = near_coord(); q.ez = near_coord() / 2 + ONE_I / 2;
        q.sw = (kind < 75) ? ONE_I : $urandom_range(2 * ONE_I, ONE_I / 2);
        q.ew = (kind < 75) ? ONE_I : $urandom_range(2 * ONE_I, ONE_I / 2);
        if (kind >= 90) q.sw = -q.sw;
        if (kind >= 95) q.ew = ($urandom_range(1)) ? 0 : -q.ew;
        q.color = ($urandom_range(1)) ? 24'd0 : 24'($urandom);
        q.width = 8'($urandom);
      end
      send_seg(q);
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_we = 0;
    cfg_index = REG_DEPTH_EN;
    cfg_data = '0;
    sent = 0;
    send_idle = 8;
    recv_idle = 87;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset settings, then a mid viewport with depth color
    send_pts(0, 0, 32768, ONE_I, 0, 0, 32768, ONE_I, 0, 0);
    set_viewport(1, 640, 480, 10);
    send_pts(-32768, -32768, 16384, ONE_I, 32768, 32768, 49152, ONE_I, 0, 255);
    send_pts(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 24'hffffff, 255);
    send_pts(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
             32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
    // both w negative, mixed w signs, zero w with zero and nonzero numerators
    send_pts(0, 0, 32768, -ONE_I, 0, 0, 32768, -ONE_I, 0, 1);
    send_pts(0, 0, -32768, -ONE_I, 0, 0, 32768, ONE_I, 0, 2);
    send_pts(0, 0, 0, 0, 0, 0, 32768, ONE_I, 0, 3);
    send_pts(5, 0, 0, 0, 0, 0, 32768, ONE_I, 0, 4);
    // straddling each plane in turn
    send_pts(-2 * ONE_I, 0, 32768, ONE_I, 0, 0, 32768, ONE_I, 0, 5);
    send_pts(0, 0, 32768, ONE_I, 2 * ONE_I, 100, 32768, ONE_I, 24'h123456, 6);
    send_pts(0, -3 * ONE_I, 32768, ONE_I, 1000, 0, 32768, ONE_I, 0, 7);
    send_pts(0, 0, 32768, ONE_I, -777, 3 * ONE_I, 20000, ONE_I, 0, 8);
    send_pts(0, 0, -ONE_I, ONE_I, 300, 200, 32768, ONE_I, 0, 9);
    send_pts(0, 0, 32768, ONE_I, 300, 200, 2 * ONE_I, ONE_I, 0, 10);
    // fully outside one plane, and ends exactly on planes
    send_pts(-2 * ONE_I, 0, 32768, ONE_I, -3 * ONE_I, 0, 32768, ONE_I, 0, 11);
    send_pts(0, 0, -5, ONE_I, 0, 0, -9, ONE_I, 0, 12);
    send_pts(-ONE_I, ONE_I, 0, ONE_I, ONE_I, -ONE_I, ONE_I, ONE_I, 0, 13);
    send_pts(ONE_I, ONE_I, ONE_I, ONE_I, ONE_I, ONE_I, ONE_I, ONE_I, 0, 14);
    // extreme viewport settings
    set_viewport(1, 4095, 4095, 255);
    send_pts(-ONE_I, -ONE_I, 0, ONE_I, ONE_I, ONE_I, ONE_I, ONE_I, 0, 15);
    send_pts(1, -1, 65535, ONE_I, -1, 1, 1, ONE_I, 0, 16);
    set_viewport(0, 0, 0, 0);
    send_pts(0, 0, 32768, ONE_I, 100, 100, 32768, ONE_I, 0, 17);

    // random phases across settings and idling patterns
    set_viewport(1, 800, 600, 10);
    send_random(300);
    send_idle = 87;
    recv_idle = 8;
    set_viewport(0, 4095, 4095, 255);
    send_random(150);
    // hold the sender until every result is back
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    send_random(150);
    send_idle = 0;
    recv_idle = 0;
    set_viewport(1, $urandom_range(4095), $urandom_range(4095), $urandom_range(255));
    send_random(300);
    send_idle = 8;
    recv_idle = 87;
    set_viewport(1, 1, 1, 0);
    send_random(300);

    wait_drained();
    $display("sent %0d segments, checked %0d results, %0d visible, over 8 register settings",
             sent, sb.checked, sb.shown_vis);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("** segment_clip_and_viewport_map: PASSED **");
    end else begin
      $display("** segment_clip_and_viewport_map: FAILED **");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/sclip_pkg.sv
src/sclip_div.sv
src/segment_clip_and_viewport_map.sv
tb/testbench.sv
